/* src/brte_pkg.sv */
// ----------------------------------------------------------------------------
// brte_pkg
// Shared types and constants for the base relocation table encoder.
// ----------------------------------------------------------------------------
package brte_pkg;

  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [3:0]  ENTRY_HIGHLOW = 4'h3;
  localparam logic [31:0] HEADER_BYTES  = 32'd8;

  // Write steps of one command, emitted lowest index first
  localparam int unsigned STEP_PAD   = 0;
  localparam int unsigned STEP_PATCH = 1;
  localparam int unsigned STEP_HDR   = 2;
  localparam int unsigned STEP_SIZE  = 3;
  localparam int unsigned STEP_ENTRY = 4;
  localparam int unsigned NUM_STEPS  = 5;

  typedef logic [NUM_STEPS-1:0] step_mask_t;

  typedef struct packed {
    step_mask_t  steps;
    logic [31:0] pad_off;
    logic [31:0] patch_off;
    logic [31:0] patch_len;
    logic [31:0] base;       // header offset of the new block, or entry offset
    logic [19:0] page_base;
    logic [11:0] entry_low;
    logic [31:0] table_len;
  } brte_cmd_t;

endpackage

/* src/brte_front.sv */
// ----------------------------------------------------------------------------
// brte_front
// Accepts add/close items, tracks the open page and table length, and turns
// each item into at most one command listing the writes it needs.
// ----------------------------------------------------------------------------
module brte_front
  import brte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [31:0] reloc_address,
  input  logic        q_full,
  output logic        push,
  output brte_cmd_t   cmd
);

  logic [31:0] table_bytes;
  logic [19:0] open_page;
  logic [31:0] header_position;

  logic [31:0] table_bytes_next;
  logic [19:0] page;
  logic        empty;
  logic        change;
  logic        closing;
  logic        opening;
  logic        pad;
  logic [31:0] len;
  logic [31:0] pad_inc;
  logic [31:0] tb1;
  logic [3:0]  inc;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    page    = reloc_address[31:PAGE_SHIFT];
    empty   = (table_bytes == 32'd0);
    change  = !empty && (page != open_page);
    closing = opcode ? !empty : change;
    opening = !opcode && (empty || change);
    len     = table_bytes - header_position;
    pad     = closing && len[1];
    pad_inc = {30'd0, pad, 1'b0};
    tb1     = table_bytes + pad_inc;
    if (opening) begin
      inc = pad ? 4'd12 : 4'd10;
    end else begin
      inc = 4'd2;
    end
    table_bytes_next = opcode ? 32'd0 : (table_bytes + {28'd0, inc});

    cmd.steps[STEP_PAD]   = pad;
    cmd.steps[STEP_PATCH] = closing;
    cmd.steps[STEP_HDR]   = opening;
    cmd.steps[STEP_SIZE]  = opening;
    cmd.steps[STEP_ENTRY] = !opcode;
    cmd.pad_off           = table_bytes;
    cmd.patch_off         = header_position + 32'd4;
    cmd.patch_len         = len + pad_inc;
    cmd.base              = tb1;
    cmd.page_base         = page;
    cmd.entry_low         = reloc_address[PAGE_SHIFT-1:0];
    cmd.table_len         = table_bytes_next;
  end

  // close on an empty table has nothing to write
  assign push = accept && (!opcode || !empty);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_bytes     <= '0;
      open_page       <= '0;
      header_position <= '0;
    end else if (accept) begin
      table_bytes <= table_bytes_next;
      if (opcode) begin
        open_page       <= '0;
        header_position <= '0;
      end else if (opening) begin
        open_page       <= page;
        header_position <= tb1;
      end
    end
  end

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode) |=> (table_bytes == 32'd0 && header_position == 32'd0))
    else $error("close did not clear table state");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("command pushed into full queue");

  a_open_has_entry: assert property (@(posedge clk) disable iff (rst)
    push |-> (cmd.steps[STEP_ENTRY] || cmd.steps[STEP_PATCH]))
    else $error("command with no closing or entry write");

endmodule

/* src/brte_queue.sv */
// ----------------------------------------------------------------------------
// brte_queue
// Small command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module brte_queue
  import brte_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  brte_cmd_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output brte_cmd_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  brte_cmd_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty command queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count beyond depth");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

endmodule

/* src/brte_back.sv */
// ----------------------------------------------------------------------------
// brte_back
// Walks the steps of the head command and emits one write per transfer
// through a registered output stage.
// ----------------------------------------------------------------------------
module brte_back
  import brte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_not_empty,
  input  brte_cmd_t   head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] byte_offset,
  output logic [31:0] data_value,
  output logic        is_word32,
  output logic        last_of_run,
  output logic [31:0] table_length
);

  step_mask_t  done;
  step_mask_t  remaining;
  step_mask_t  sel;
  logic        last;
  logic        advance;
  logic        emit;
  logic [31:0] off_add;
  logic [31:0] wr_off;
  logic [31:0] wr_data;
  logic        wr_word;

  assign remaining = head.steps & ~done;
  assign sel       = remaining & (~remaining + 1'b1); // lowest pending step
  assign last      = ((remaining & ~sel) == '0);
  assign advance   = !out_valid || !out_stall;
  assign emit      = advance && q_not_empty;
  assign pop       = emit && last;

  always_comb begin
    off_add = 32'd0;
    wr_data = 32'd0;
    wr_word = 1'b1;
    wr_off  = head.base;
    if (sel[STEP_PAD]) begin
      wr_off  = head.pad_off;
      wr_word = 1'b0;
    end else if (sel[STEP_PATCH]) begin
      wr_off  = head.patch_off;
      wr_data = head.patch_len;
    end else if (sel[STEP_HDR]) begin
      wr_data = {head.page_base, {PAGE_SHIFT{1'b0}}};
    end else if (sel[STEP_SIZE]) begin
      off_add = 32'd4;
      wr_data = HEADER_BYTES;
    end else begin
      off_add = head.steps[STEP_HDR] ? 32'd8 : 32'd0;
      wr_data = {16'd0, ENTRY_HIGHLOW, head.entry_low};
      wr_word = 1'b0;
    end
    if (!sel[STEP_PAD] && !sel[STEP_PATCH]) begin
      wr_off = head.base + off_add;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else if (advance) begin
      out_valid <= q_not_empty;
      if (emit) begin
        done <= last ? '0 : (done | sel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_offset  <= wr_off;
      data_value   <= wr_data;
      is_word32    <= wr_word;
      last_of_run  <= last;
      table_length <= head.table_len;
    end
  end

  a_done_subset: assert property (@(posedge clk) disable iff (rst)
    q_not_empty |-> ((done & ~head.steps) == '0))
    else $error("finished steps outside head command");

  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    emit |-> $onehot(sel))
    else $error("no single step chosen for a write");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    !q_not_empty |-> (done == '0))
    else $error("step progress kept with empty queue");

endmodule

/* src/base_relocation_table_encoder_unit.sv */
// ----------------------------------------------------------------------------
// base_relocation_table_encoder_unit
// Base relocation table encoder: add/close items in, byte-offset writes out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): opcode 0 adds reloc_address, opcode 1
// closes the table. Output channel (out_valid/out_stall): one transfer per
// table write, with byte_offset, data_value, is_word32, last_of_run and
// table_length (the length after the whole item).
// An add in the open page makes one write; an add that opens a page makes
// three, plus one or two more when it closes the previous page. A close
// makes one or two writes, none on an empty table.
// With the queue empty, the first write of an item passes through the command
// queue and then the registered output stage. The back end emits one write per
// cycle while the output is not stalled, so the table sustains one item per
// cycle while pages stay the same; multi-write items drain through the command
// queue (DEPTH entries), and input stalls only when that queue is full.
// A stalled output holds its write; the queue keeps taking items until full.
// Reset clears the table length, open page and header position, empties the
// queue and drops out_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module base_relocation_table_encoder_unit
  import brte_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [31:0] reloc_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] byte_offset,
  output logic [31:0] data_value,
  output logic        is_word32,
  output logic        last_of_run,
  output logic [31:0] table_length
);

  brte_cmd_t push_cmd;
  brte_cmd_t head_cmd;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_not_empty;

  brte_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .reloc_address (reloc_address),
    .q_full        (q_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  brte_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  brte_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .head         (head_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_offset  (byte_offset),
    .data_value   (data_value),
    .is_word32    (is_word32),
    .last_of_run  (last_of_run),
    .table_length (table_length)
  );

endmodule
